[hdl/current_sense_block_averager_assert.svh]
// Assertion macros shared by the current-sense block averager.
`ifndef CURRENT_SENSE_BLOCK_AVERAGER_ASSERT_SVH
`define CURRENT_SENSE_BLOCK_AVERAGER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CSBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/csba_pkg.sv]
// Shared widths, register indexes and scaling constants of the current-sense averager.
`default_nettype none

package csba_pkg;

    // Default converter resolution.
    localparam int ADC_BITS_DEFAULT = 12;

    // Field and state widths.
    localparam int AVG_W   = 16;
    localparam int MA_W    = 21;
    localparam int SUM_W   = 24;
    localparam int COUNT_W = 8;
    localparam int PROD_W  = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CREST_LIMIT = 2'd2;

    // Register reset values.
    localparam int ZERO_OFFSET_RESET = 0;
    localparam int BLOCK_COUNT_RESET = 16;
    localparam int CREST_LIMIT_RESET = 400;

    // Milliamp conversion: floor(avg * 50000 / 2^ADC_BITS) - 1000, saturated at the top.
    localparam logic [15:0]       MA_SCALE  = 16'd50000;
    localparam int                MA_OFFSET = 1000;
    localparam int                MA_MAX    = 1048575;
    localparam logic [MA_W-1:0]   MA_AT_ZERO_AVG = MA_W'(0) - MA_W'(MA_OFFSET);

endpackage

`default_nettype wire

[hdl/current_sense_block_averager.sv]
// Top level of the current-sense block averager with offset removal.
`default_nettype none

// Each request carries one ADC sample. A sample above crest_limit counts as zero,
// zero_offset is subtracted modulo 2^16 and the result is added to a 24-bit running sum.
// When block_count samples have been gathered the sum is divided by block_count in a
// restoring divider, one quotient bit per cycle, and the average is latched and
// converted to milliamps by one 16 x 16 multiply. Every request returns one result: the
// held average, its current in milliamps and a block-done flag. A sample that does not
// close a block passes through load, accumulate and output; a sample that closes a
// block also passes through the 24 iterations of the divider, the multiply and the
// milliamp scaling before output. A finished result sits in an output register, so
// the next request is taken while it waits. Configuration writes are
// accepted at any time and must only be issued while the block is idle.
module current_sense_block_averager #(
    parameter int ADC_BITS = csba_pkg::ADC_BITS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Sample channel.
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ADC_BITS-1:0]               s_sample,
    // Result channel.
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [csba_pkg::AVG_W-1:0]             m_average,
    output logic signed [csba_pkg::MA_W-1:0]       m_current_ma,
    output logic                                   m_block_done,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [csba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [csba_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import csba_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SCL  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam int ITER_W = $clog2(SUM_W);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SUM_W - 1);
    localparam logic [PROD_W-1:0] SCALED_SAT = PROD_W'(MA_MAX + MA_OFFSET);

    // Control state.
    logic [2:0]             state_reg, state_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   done_reg, done_next;

    // Configuration registers.
    logic [ADC_BITS-1:0]    zero_offset_reg;
    logic [COUNT_W-1:0]     block_count_reg;
    logic [ADC_BITS-1:0]    crest_limit_reg;

    // Block state.
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [AVG_W-1:0]       held_avg_reg, held_avg_next;
    logic [MA_W-1:0]        current_reg, current_next;

    // Datapath registers.
    logic [ADC_BITS-1:0]    sample_reg, sample_next;
    logic [SUM_W-1:0]       quo_reg, quo_next;
    logic [COUNT_W-1:0]     rem_reg, rem_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [AVG_W-1:0]       out_avg_reg, out_avg_next;
    logic [MA_W-1:0]        out_ma_reg, out_ma_next;
    logic                   out_done_reg, out_done_next;

    // Combinational helpers.
    logic [COUNT_W-1:0]     divisor;
    logic [ADC_BITS-1:0]    clipped;
    logic [AVG_W-1:0]       corrected;
    logic [COUNT_W:0]       rem_shift;
    logic [COUNT_W+1:0]     diff;
    logic                   quo_bit;
    logic [PROD_W-1:0]      scaled;
    logic                   out_free;

    // A block count of zero behaves as one.
    assign divisor = (block_count_reg == '0) ? COUNT_W'(1) : block_count_reg;

    // Crest clipping and offset removal of the held sample.
    assign clipped   = (sample_reg > crest_limit_reg) ? '0 : sample_reg;
    assign corrected = AVG_W'(clipped) - AVG_W'(zero_offset_reg);

    // Restoring divider step: shift in the next dividend bit, trial subtract.
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, divisor};
    assign quo_bit   = ~diff[COUNT_W+1];

    // Scaled reading before the milliamp offset.
    assign scaled = prod_reg >> ADC_BITS;

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer and datapath next values.
    always_comb begin
        state_next    = state_reg;
        iter_next     = iter_reg;
        m_valid_next  = m_valid_reg;
        done_next     = done_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        held_avg_next = held_avg_reg;
        current_next  = current_reg;
        sample_next   = sample_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        prod_next     = prod_reg;
        out_avg_next  = out_avg_reg;
        out_ma_next   = out_ma_reg;
        out_done_next = out_done_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_sample;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC: begin
                // Add only while the block is still short; a lowered count closes it at once.
                if (count_reg < divisor) begin
                    sum_next   = sum_reg + SUM_W'(corrected);
                    count_next = count_reg + COUNT_W'(1);
                end
                if (count_next >= divisor) begin
                    quo_next   = sum_next;
                    rem_next   = '0;
                    iter_next  = '0;
                    state_next = ST_DIV;
                end else begin
                    done_next  = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                rem_next  = quo_bit ? diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], quo_bit};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_LAST) begin
                    held_avg_next = (|quo_next[SUM_W-1:AVG_W]) ? '1 : quo_next[AVG_W-1:0];
                    count_next    = '0;
                    sum_next      = '0;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(held_avg_reg) * PROD_W'(MA_SCALE);
                state_next = ST_SCL;
            end
            ST_SCL: begin
                current_next = (scaled > SCALED_SAT) ? MA_W'(MA_MAX)
                                                     : MA_W'(scaled - PROD_W'(MA_OFFSET));
                done_next    = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_avg_next  = held_avg_reg;
                    out_ma_next   = current_reg;
                    out_done_next = done_reg;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and held state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            iter_reg     <= '0;
            m_valid_reg  <= 1'b0;
            done_reg     <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            held_avg_reg <= '0;
            current_reg  <= MA_AT_ZERO_AVG;
        end else begin
            state_reg    <= state_next;
            iter_reg     <= iter_next;
            m_valid_reg  <= m_valid_next;
            done_reg     <= done_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            held_avg_reg <= held_avg_next;
            current_reg  <= current_next;
        end
    end

    // Configuration registers, masked to their widths.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_offset_reg <= ADC_BITS'(ZERO_OFFSET_RESET);
            block_count_reg <= COUNT_W'(BLOCK_COUNT_RESET);
            crest_limit_reg <= ADC_BITS'(CREST_LIMIT_RESET);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ZERO_OFFSET: zero_offset_reg <= cfg_data[ADC_BITS-1:0];
                REG_BLOCK_COUNT: block_count_reg <= cfg_data[COUNT_W-1:0];
                REG_CREST_LIMIT: crest_limit_reg <= cfg_data[ADC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        prod_reg     <= prod_next;
        out_avg_reg  <= out_avg_next;
        out_ma_reg   <= out_ma_next;
        out_done_reg <= out_done_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_average    = out_avg_reg;
    assign m_current_ma = out_ma_reg;
    assign m_block_done = out_done_reg;

    // Checks on the sequencer and datapath.
`include "current_sense_block_averager_assert.svh"

    `CSBA_ASSERT_NEXT(a_one_request_at_a_time, s_valid && s_ready, !s_ready,
        "A second request was taken before the first finished.")
    `CSBA_ASSERT_NOW(a_block_cleared, state_reg == ST_OUT && done_reg,
        count_reg == '0 && sum_reg == '0,
        "A completed block left a non-zero count or sum.")
    `CSBA_ASSERT_NOW(a_product_matches, state_reg == ST_SCL,
        prod_reg == PROD_W'(held_avg_reg) * PROD_W'(MA_SCALE),
        "The milliamp product does not match the held average.")
    `CSBA_ASSERT_NOW(a_remainder_bound, state_reg == ST_DIV, rem_reg < divisor,
        "The divider remainder reached the divisor.")

endmodule

`default_nettype wire
